// ===== src/split_virtqueue_driver_ring_macros.svh =====
// ----------------------------------------------------------------------------
// split_virtqueue_driver_ring assertion macros
// Shorthand for the concurrent checks at the end of the top level. Each use
// expects aclk and aresetn to be visible where it is expanded.
// ----------------------------------------------------------------------------
`ifndef SPLIT_VIRTQUEUE_DRIVER_RING_MACROS_SVH
`define SPLIT_VIRTQUEUE_DRIVER_RING_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SVDR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define SVDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/svdr_pkg.sv =====
// ----------------------------------------------------------------------------
// svdr_pkg
// Shared sizes, codes and control bundles of the split virtqueue driver ring.
// ----------------------------------------------------------------------------
package svdr_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int RIDX_W      = 16;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 32;
    localparam int QSIZE_W     = 9;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

    // Descriptor word: {write flag, length, address}. Used entry: {id, length}.
    localparam int DESC_W = ADDR_W + LEN_W + 1;
    localparam int USED_W = IDX_W + LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_QSIZE = '0;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_POST = 2'd1,
        OP_GET  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_NO_USED = 2'd2,
        STAT_BAD_ID  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_LINK,
        ST_POST_WRITE,
        ST_GET_RECLAIM,
        ST_GET_ADDR,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_INC,
        ALU_DIST
    } alu_func_t;

    typedef struct packed {
        alu_func_t         func;
        logic [RIDX_W-1:0] idx_a;
        logic [RIDX_W-1:0] idx_b;
        logic [IDX_W-1:0]  slot;
    } alu_req_t;

    typedef struct packed {
        logic [RIDX_W-1:0] idx;
        logic [IDX_W-1:0]  slot;
        logic              at_limit;
    } alu_rsp_t;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } link_ctl_t;

    // A written queue size of zero means one; anything above the table depth
    // means the full table.
    function automatic logic [CNT_W-1:0] clamp_qsize(input logic [QSIZE_W-1:0] value);
        int n;
        n = int'(value);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_ENTRIES) begin
            n = MAX_ENTRIES;
        end
        return CNT_W'(n);
    endfunction

endpackage

// ===== src/svdr_ram.sv =====
// ----------------------------------------------------------------------------
// svdr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module svdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/svdr_alu.sv =====
// ----------------------------------------------------------------------------
// svdr_alu
// Shared ring index unit: advances a 16-bit ring index together with its
// slot in the ring, or measures the distance between two ring indices.
// ----------------------------------------------------------------------------
module svdr_alu (
    input  svdr_pkg::alu_req_t              req,
    input  logic [svdr_pkg::CNT_W-1:0]      qsize,
    output svdr_pkg::alu_rsp_t              rsp
);

    localparam int RIDX_W = svdr_pkg::RIDX_W;
    localparam int CNT_W  = svdr_pkg::CNT_W;
    localparam int IDX_W  = svdr_pkg::IDX_W;

    logic [RIDX_W-1:0] operand_b;
    logic [RIDX_W-1:0] sum;
    logic [CNT_W-1:0]  slot_inc;

    always_comb begin
        operand_b = (req.func == svdr_pkg::ALU_INC) ? RIDX_W'(1) : (~req.idx_b + RIDX_W'(1));
        sum       = req.idx_a + operand_b;
        slot_inc  = CNT_W'(req.slot) + CNT_W'(1);

        rsp.idx      = sum;
        rsp.slot     = req.slot;
        rsp.at_limit = 1'b0;

        unique case (req.func)
            svdr_pkg::ALU_INC: begin
                // When the 16-bit index wraps to zero, its slot restarts too.
                if ((sum == '0) || (slot_inc == qsize)) begin
                    rsp.slot = '0;
                end else begin
                    rsp.slot = slot_inc[IDX_W-1:0];
                end
            end
            svdr_pkg::ALU_DIST: begin
                rsp.at_limit = (sum >= RIDX_W'(qsize));
            end
        endcase
    end

endmodule

// ===== src/svdr_link.sv =====
// ----------------------------------------------------------------------------
// svdr_link
// Free list link table. Entries not written since the last relink read as
// their successor index, with the last entry of the queue wrapping to zero.
// ----------------------------------------------------------------------------
module svdr_link (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  svdr_pkg::link_ctl_t         ctl,
    input  logic [svdr_pkg::CNT_W-1:0]  qsize,
    output logic [svdr_pkg::IDX_W-1:0]  rd_data
);

    localparam int MAX_ENTRIES = svdr_pkg::MAX_ENTRIES;
    localparam int IDX_W       = svdr_pkg::IDX_W;
    localparam int CNT_W       = svdr_pkg::CNT_W;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic [IDX_W-1:0]       ram_q;
    logic [CNT_W-1:0]       succ;
    logic [IDX_W-1:0]       dflt;

    svdr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (ctl.wr_addr),
        .wr_data (ctl.wr_data),
        .rd_addr (ctl.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= ctl.rd_addr;
    end

    always_comb begin
        succ    = CNT_W'(rd_addr_reg) + CNT_W'(1);
        dflt    = (succ < qsize) ? succ[IDX_W-1:0] : '0;
        rd_data = rd_valid_reg ? ram_q : dflt;
    end

endmodule

// ===== src/split_virtqueue_driver_ring.sv =====
// ----------------------------------------------------------------------------
// split_virtqueue_driver_ring
// Driver side of a single-descriptor split virtqueue: allocates descriptors
// from a linked free list, records host completions in the used ring and
// reclaims completed buffers.
//
//   Channel  Direction  Handshake        Payload
//   s_       in         s_valid/s_ready  opcode, buffer, used entry
//   m_       out        m_valid/m_ready  status, head, address, length, slot
//   APB      in         psel/penable     queue size at byte address 0
//
// Each item passes DISPATCH and then DONE, with ADD_LINK between them for add,
// POST_WRITE for post and GET_RECLAIM then GET_ADDR for get, as the registered
// memory reads and the one shared ring index unit require. s_ready is high only
// in IDLE, so no item is taken while another is in progress. Reset and a queue
// size write relink the free list at once through per-entry valid bits. A result
// waiting on m_ready holds the block in its final state.
// ----------------------------------------------------------------------------
`include "split_virtqueue_driver_ring_macros.svh"

module split_virtqueue_driver_ring (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [svdr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [svdr_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [svdr_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [svdr_pkg::ADDR_W-1:0]         s_buf_addr,
    input  logic [svdr_pkg::LEN_W-1:0]          s_buf_len,
    input  logic                                s_device_writes,
    input  logic [svdr_pkg::IDX_W-1:0]          s_used_id,
    input  logic [svdr_pkg::LEN_W-1:0]          s_used_len,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [svdr_pkg::IDX_W-1:0]          m_head,
    output logic [svdr_pkg::ADDR_W-1:0]         m_ret_addr,
    output logic [svdr_pkg::LEN_W-1:0]          m_ret_len,
    output logic [svdr_pkg::IDX_W-1:0]          m_avail_slot,
    output logic [svdr_pkg::CNT_W-1:0]          m_free_count
);

    localparam int MAX_ENTRIES = svdr_pkg::MAX_ENTRIES;
    localparam int IDX_W       = svdr_pkg::IDX_W;
    localparam int CNT_W       = svdr_pkg::CNT_W;
    localparam int RIDX_W      = svdr_pkg::RIDX_W;
    localparam int ADDR_W      = svdr_pkg::ADDR_W;
    localparam int LEN_W       = svdr_pkg::LEN_W;
    localparam int DESC_W      = svdr_pkg::DESC_W;
    localparam int USED_W      = svdr_pkg::USED_W;
    localparam int CFG_DATA_W  = svdr_pkg::CFG_DATA_W;
    localparam int CFG_ADDR_W  = svdr_pkg::CFG_ADDR_W;
    localparam int QSIZE_W     = svdr_pkg::QSIZE_W;

    svdr_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  qsize_reg, qsize_next;
    logic [CNT_W-1:0]  free_total_reg, free_total_next;
    logic [IDX_W-1:0]  free_top_reg, free_top_next;
    logic [RIDX_W-1:0] avail_ptr_reg, avail_ptr_next;
    logic [IDX_W-1:0]  avail_slot_reg, avail_slot_next;
    logic [RIDX_W-1:0] used_ptr_reg, used_ptr_next;
    logic [IDX_W-1:0]  used_slot_reg, used_slot_next;
    logic [RIDX_W-1:0] seen_idx_reg, seen_idx_next;
    logic [IDX_W-1:0]  seen_slot_reg, seen_slot_next;
    logic              m_valid_reg, m_valid_next;

    // Item fields held for the length of the operation.
    logic [1:0]        op_reg;
    logic [ADDR_W-1:0] buf_addr_reg;
    logic [LEN_W-1:0]  buf_len_reg;
    logic              dev_wr_reg;
    logic [IDX_W-1:0]  used_id_reg;
    logic [LEN_W-1:0]  used_len_reg;

    // Result under construction.
    logic [1:0]        res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_head_reg, res_head_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;

    logic [1:0]        m_status_reg;
    logic [IDX_W-1:0]  m_head_reg;
    logic [ADDR_W-1:0] m_ret_addr_reg;
    logic [LEN_W-1:0]  m_ret_len_reg;
    logic [IDX_W-1:0]  m_avail_slot_reg;
    logic [CNT_W-1:0]  m_free_count_reg;

    logic              in_xfer;
    logic              load_out;
    logic              cfg_hit;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_qsize;

    svdr_pkg::alu_req_t  alu_req;
    svdr_pkg::alu_rsp_t  alu_rsp;
    svdr_pkg::link_ctl_t link_ctl;
    logic [IDX_W-1:0]    link_q;

    logic              desc_we;
    logic [IDX_W-1:0]  desc_raddr;
    logic [DESC_W-1:0] desc_q;
    logic              used_we;
    logic [USED_W-1:0] used_q;
    logic [IDX_W-1:0]  reclaim_head;

    svdr_alu u_alu (
        .req   (alu_req),
        .qsize (qsize_reg),
        .rsp   (alu_rsp)
    );

    svdr_link u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (link_ctl),
        .qsize   (qsize_reg),
        .rd_data (link_q)
    );

    svdr_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (desc_we),
        .wr_addr (res_head_reg),
        .wr_data ({dev_wr_reg, buf_len_reg, buf_addr_reg}),
        .rd_addr (desc_raddr),
        .rd_data (desc_q)
    );

    svdr_ram #(
        .WIDTH (USED_W),
        .DEPTH (MAX_ENTRIES)
    ) u_used_ram (
        .aclk    (aclk),
        .wr_en   (used_we),
        .wr_addr (used_slot_reg),
        .wr_data ({used_id_reg, used_len_reg}),
        .rd_addr (seen_slot_reg),
        .rd_data (used_q)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[CFG_ADDR_W-1:2] == svdr_pkg::REG_QSIZE);
    assign cfg_we    = psel && penable && pwrite && cfg_hit;
    assign cfg_qsize = svdr_pkg::clamp_qsize(pwdata[QSIZE_W-1:0]);
    assign prdata    = cfg_hit ? CFG_DATA_W'(qsize_reg) : '0;

    assign s_ready      = (state_reg == svdr_pkg::ST_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign reclaim_head = used_q[USED_W-1 -: IDX_W];

    always_comb begin
        state_next      = state_reg;
        qsize_next      = qsize_reg;
        free_total_next = free_total_reg;
        free_top_next   = free_top_reg;
        avail_ptr_next  = avail_ptr_reg;
        avail_slot_next = avail_slot_reg;
        used_ptr_next   = used_ptr_reg;
        used_slot_next  = used_slot_reg;
        seen_idx_next   = seen_idx_reg;
        seen_slot_next  = seen_slot_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        res_addr_next   = res_addr_reg;
        res_len_next    = res_len_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        load_out        = 1'b0;

        alu_req.func  = svdr_pkg::ALU_INC;
        alu_req.idx_a = avail_ptr_reg;
        alu_req.idx_b = seen_idx_reg;
        alu_req.slot  = avail_slot_reg;

        link_ctl.clear   = 1'b0;
        link_ctl.wr_en   = 1'b0;
        link_ctl.wr_addr = res_head_reg;
        link_ctl.wr_data = '0;
        link_ctl.rd_addr = free_top_reg;

        desc_we    = 1'b0;
        desc_raddr = reclaim_head;
        used_we    = 1'b0;

        // A queue size write relinks the free list and restarts all rings.
        if (cfg_we) begin
            qsize_next      = cfg_qsize;
            free_total_next = cfg_qsize;
            free_top_next   = '0;
            avail_ptr_next  = '0;
            avail_slot_next = '0;
            used_ptr_next   = '0;
            used_slot_next  = '0;
            seen_idx_next   = '0;
            seen_slot_next  = '0;
            link_ctl.clear  = 1'b1;
        end

        unique case (state_reg)
            svdr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = svdr_pkg::ST_DISPATCH;
                end
            end

            svdr_pkg::ST_DISPATCH: begin
                res_status_next = svdr_pkg::STAT_OK;
                res_head_next   = '0;
                res_addr_next   = '0;
                res_len_next    = '0;
                res_slot_next   = '0;
                state_next      = svdr_pkg::ST_DONE;
                unique case (op_reg)
                    svdr_pkg::OP_ADD: begin
                        if (free_total_reg == '0) begin
                            res_status_next = svdr_pkg::STAT_NO_FREE;
                        end else begin
                            res_head_next = free_top_reg;
                            state_next    = svdr_pkg::ST_ADD_LINK;
                        end
                    end
                    svdr_pkg::OP_POST: begin
                        res_head_next = used_id_reg;
                        alu_req.func  = svdr_pkg::ALU_DIST;
                        alu_req.idx_a = used_ptr_reg;
                        alu_req.idx_b = seen_idx_reg;
                        if (CNT_W'(used_id_reg) >= qsize_reg) begin
                            res_status_next = svdr_pkg::STAT_BAD_ID;
                        end else if (alu_rsp.at_limit) begin
                            res_status_next = svdr_pkg::STAT_NO_FREE;
                        end else begin
                            state_next = svdr_pkg::ST_POST_WRITE;
                        end
                    end
                    svdr_pkg::OP_GET: begin
                        if (seen_idx_reg == used_ptr_reg) begin
                            res_status_next = svdr_pkg::STAT_NO_USED;
                        end else begin
                            state_next = svdr_pkg::ST_GET_RECLAIM;
                        end
                    end
                    default: begin
                        res_status_next = svdr_pkg::STAT_BAD_ID;
                    end
                endcase
            end

            svdr_pkg::ST_ADD_LINK: begin
                // The link read issued in dispatch has returned the next free head.
                free_top_next    = link_q;
                free_total_next  = free_total_reg - CNT_W'(1);
                desc_we          = 1'b1;
                link_ctl.wr_en   = 1'b1;
                link_ctl.wr_addr = res_head_reg;
                link_ctl.wr_data = '0;
                res_slot_next    = avail_slot_reg;
                avail_ptr_next   = alu_rsp.idx;
                avail_slot_next  = alu_rsp.slot;
                state_next       = svdr_pkg::ST_DONE;
            end

            svdr_pkg::ST_POST_WRITE: begin
                used_we        = 1'b1;
                alu_req.idx_a  = used_ptr_reg;
                alu_req.slot   = used_slot_reg;
                used_ptr_next  = alu_rsp.idx;
                used_slot_next = alu_rsp.slot;
                state_next     = svdr_pkg::ST_DONE;
            end

            svdr_pkg::ST_GET_RECLAIM: begin
                // Push the reclaimed descriptor back on the free list.
                res_head_next    = reclaim_head;
                res_len_next     = used_q[LEN_W-1:0];
                link_ctl.wr_en   = 1'b1;
                link_ctl.wr_addr = reclaim_head;
                link_ctl.wr_data = free_top_reg;
                free_top_next    = reclaim_head;
                if (free_total_reg < qsize_reg) begin
                    free_total_next = free_total_reg + CNT_W'(1);
                end
                desc_raddr     = reclaim_head;
                alu_req.idx_a  = seen_idx_reg;
                alu_req.slot   = seen_slot_reg;
                seen_idx_next  = alu_rsp.idx;
                seen_slot_next = alu_rsp.slot;
                state_next     = svdr_pkg::ST_GET_ADDR;
            end

            svdr_pkg::ST_GET_ADDR: begin
                res_addr_next = desc_q[ADDR_W-1:0];
                state_next    = svdr_pkg::ST_DONE;
            end

            svdr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = svdr_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = svdr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= svdr_pkg::ST_IDLE;
            qsize_reg      <= CNT_W'(MAX_ENTRIES);
            free_total_reg <= CNT_W'(MAX_ENTRIES);
            free_top_reg   <= '0;
            avail_ptr_reg  <= '0;
            avail_slot_reg <= '0;
            used_ptr_reg   <= '0;
            used_slot_reg  <= '0;
            seen_idx_reg   <= '0;
            seen_slot_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            qsize_reg      <= qsize_next;
            free_total_reg <= free_total_next;
            free_top_reg   <= free_top_next;
            avail_ptr_reg  <= avail_ptr_next;
            avail_slot_reg <= avail_slot_next;
            used_ptr_reg   <= used_ptr_next;
            used_slot_reg  <= used_slot_next;
            seen_idx_reg   <= seen_idx_next;
            seen_slot_reg  <= seen_slot_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg       <= s_opcode;
            buf_addr_reg <= s_buf_addr;
            buf_len_reg  <= s_buf_len;
            dev_wr_reg   <= s_device_writes;
            used_id_reg  <= s_used_id;
            used_len_reg <= s_used_len;
        end
        res_status_reg <= res_status_next;
        res_head_reg   <= res_head_next;
        res_addr_reg   <= res_addr_next;
        res_len_reg    <= res_len_next;
        res_slot_reg   <= res_slot_next;
        if (load_out) begin
            m_status_reg     <= res_status_reg;
            m_head_reg       <= res_head_reg;
            m_ret_addr_reg   <= res_addr_reg;
            m_ret_len_reg    <= res_len_reg;
            m_avail_slot_reg <= res_slot_reg;
            m_free_count_reg <= free_total_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_head       = m_head_reg;
    assign m_ret_addr   = m_ret_addr_reg;
    assign m_ret_len    = m_ret_len_reg;
    assign m_avail_slot = m_avail_slot_reg;
    assign m_free_count = m_free_count_reg;

    `SVDR_ASSERT_ALWAYS(a_free_total_bound, free_total_reg <= qsize_reg, "free count above queue size")
    `SVDR_ASSERT_ALWAYS(a_free_top_bound, CNT_W'(free_top_reg) < qsize_reg, "free head outside queue")
    `SVDR_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready stayed high after a transfer")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: split virtqueue driver ring testbench
// Sends add, post, get and illegal operations with random gaps on both
// channels. A built-in model of the descriptor table, free list and both rings
// predicts each reply, and every reply is compared field by field. The queue
// size is rewritten between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb;
    import svdr_pkg::*;

    localparam logic [1:0] OP_ILLEGAL   = 2'd3;
    localparam int         GEN_VIEW     = 0;
    localparam int         DUT_VIEW     = 1;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         PHASES       = 11;
    localparam int         CHUNK_OPS    = 75;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              dev_wr;
        logic [IDX_W-1:0]  id;
        logic [LEN_W-1:0]  used_len;
    } vq_op_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  head;
        logic [ADDR_W-1:0] ret_addr;
        logic [LEN_W-1:0]  ret_len;
        logic [IDX_W-1:0]  avail_slot;
        logic [CNT_W-1:0]  free_count;
    } vq_reply_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr           = '0;
    logic [CFG_DATA_W-1:0] pwdata          = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode        = '0;
    logic [ADDR_W-1:0]     s_buf_addr      = '0;
    logic [LEN_W-1:0]      s_buf_len       = '0;
    logic                  s_device_writes = 1'b0;
    logic [IDX_W-1:0]      s_used_id       = '0;
    logic [LEN_W-1:0]      s_used_len      = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [1:0]            m_status;
    logic [IDX_W-1:0]      m_head;
    logic [ADDR_W-1:0]     m_ret_addr;
    logic [LEN_W-1:0]      m_ret_len;
    logic [IDX_W-1:0]      m_avail_slot;
    logic [CNT_W-1:0]      m_free_count;

    // Two copies of the ring state: one tracks what the stimulus has planned,
    // the other follows the transfers the block actually takes.
    logic [ADDR_W-1:0] buf_addr_tab [2][MAX_ENTRIES];
    logic              written_tab  [2][MAX_ENTRIES];
    int                next_free    [2][MAX_ENTRIES];
    int                used_id_tab  [2][MAX_ENTRIES];
    logic [LEN_W-1:0]  used_len_tab [2][MAX_ENTRIES];
    logic [15:0]       avail_ptr    [2];
    logic [15:0]       used_ptr     [2];
    logic [15:0]       seen_idx     [2];
    int                free_total   [2];
    int                free_top     [2];
    int                qsize        [2];

    vq_op_t    queued_ops[$];
    vq_reply_t awaited_replies[$];
    int        awaiting_post[$];
    int        ops_in_flight   = 0;
    int        mismatches      = 0;
    int        replies_checked = 0;
    int        sizes_written   = 0;
    int        op_count   [4]  = '{0, 0, 0, 0};
    int        stat_count [4]  = '{0, 0, 0, 0};
    int        size_plan  [PHASES] = '{256, 3, 300, 1, 8, 511, 5, 2, -1, 4, 16};
    int        tx_gap_max      = 9;
    int        rx_gap_max      = 9;
    int        tx_wait         = 0;
    int        rx_wait         = 0;
    int        idle_cycles     = 0;
    logic      in_fired        = 1'b0;
    logic      reply_fired     = 1'b0;
    logic      long_hold_done  = 1'b0;

    split_virtqueue_driver_ring uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_buf_addr      (s_buf_addr),
        .s_buf_len       (s_buf_len),
        .s_device_writes (s_device_writes),
        .s_used_id       (s_used_id),
        .s_used_len      (s_used_len),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_head          (m_head),
        .m_ret_addr      (m_ret_addr),
        .m_ret_len       (m_ret_len),
        .m_avail_slot    (m_avail_slot),
        .m_free_count    (m_free_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Rebuild the free list as 0 -> 1 -> ... -> size-1 and clear all indices.
    function automatic void ring_relink(input int v);
        int i;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            next_free[v][i] = (i + 1 < qsize[v]) ? i + 1 : 0;
        end
        avail_ptr[v]  = '0;
        used_ptr[v]   = '0;
        seen_idx[v]   = '0;
        free_total[v] = qsize[v];
        free_top[v]   = 0;
    endfunction

    function automatic void ring_reset(input int v);
        int i;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            buf_addr_tab[v][i] = '0;
            written_tab[v][i]  = 1'b0;
            used_id_tab[v][i]  = 0;
            used_len_tab[v][i] = '0;
        end
        qsize[v] = MAX_ENTRIES;
        ring_relink(v);
    endfunction

    function automatic void ring_configure(input int v, input logic [CFG_DATA_W-1:0] value);
        int n;
        n = int'(value[QSIZE_W-1:0]);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_ENTRIES) begin
            n = MAX_ENTRIES;
        end
        qsize[v] = n;
        ring_relink(v);
    endfunction

    function automatic vq_reply_t virtqueue_step(input int v, input vq_op_t op);
        vq_reply_t   r;
        int          hd;
        int          slot;
        logic [15:0] depth;
        r = '0;
        case (op.op)
            OP_ADD: begin
                if (free_total[v] == 0) begin
                    r.status = STAT_NO_FREE;
                end else begin
                    hd = free_top[v] % qsize[v];
                    free_top[v] = next_free[v][hd] % qsize[v];
                    buf_addr_tab[v][hd] = op.addr;
                    written_tab[v][hd] = 1'b1;
                    next_free[v][hd] = 0;
                    free_total[v]--;
                    slot = int'(avail_ptr[v]) % qsize[v];
                    avail_ptr[v] = avail_ptr[v] + 16'd1;
                    r.head = IDX_W'(hd);
                    r.avail_slot = IDX_W'(slot);
                end
            end
            OP_POST: begin
                r.head = op.id;
                depth = used_ptr[v] - seen_idx[v];
                if (int'(op.id) >= qsize[v]) begin
                    r.status = STAT_BAD_ID;
                end else if (int'(depth) >= qsize[v]) begin
                    r.status = STAT_NO_FREE;
                end else begin
                    slot = int'(used_ptr[v]) % qsize[v];
                    used_id_tab[v][slot] = int'(op.id);
                    used_len_tab[v][slot] = op.used_len;
                    used_ptr[v] = used_ptr[v] + 16'd1;
                end
            end
            OP_GET: begin
                if (seen_idx[v] == used_ptr[v]) begin
                    r.status = STAT_NO_USED;
                end else begin
                    slot = int'(seen_idx[v]) % qsize[v];
                    hd = used_id_tab[v][slot] % qsize[v];
                    r.ret_len = used_len_tab[v][slot];
                    seen_idx[v] = seen_idx[v] + 16'd1;
                    // A reclaim pushes onto the free list even for a repeated
                    // post; only the count saturates.
                    next_free[v][hd] = free_top[v];
                    free_top[v] = hd;
                    if (free_total[v] < qsize[v]) begin
                        free_total[v]++;
                    end
                    r.head = IDX_W'(hd);
                    r.ret_addr = buf_addr_tab[v][hd];
                end
            end
            default: begin
                r.status = STAT_BAD_ID;
            end
        endcase
        r.free_count = CNT_W'(free_total[v]);
        return r;
    endfunction

    function automatic vq_op_t make_op(input logic [1:0] code, input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len, input logic dev_wr,
                                       input logic [IDX_W-1:0] id,
                                       input logic [LEN_W-1:0] used_len);
        vq_op_t op;
        op.op       = code;
        op.addr     = addr;
        op.len      = len;
        op.dev_wr   = dev_wr;
        op.id       = id;
        op.used_len = used_len;
        return op;
    endfunction

    // Mostly the normal add/post/get flow, posting descriptors that are out
    // with the host. Some posts repeat an old id or use one at or above the queue
    // size. Posts inside the queue never name a descriptor never filled in.
    function automatic vq_op_t random_op();
        vq_op_t op;
        int     pick;
        int     sub;
        int     r;
        op.op       = OP_GET;
        op.addr     = {$urandom, $urandom};
        op.len      = $urandom;
        op.dev_wr   = 1'($urandom);
        op.id       = IDX_W'($urandom);
        op.used_len = $urandom;
        case ($urandom_range(0, 15))
            0: op.addr = '0;
            1: op.addr = '1;
            2: begin
                op.len      = '0;
                op.used_len = '1;
            end
            3: begin
                op.len      = '1;
                op.used_len = '0;
            end
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        r    = $urandom_range(0, qsize[GEN_VIEW] - 1);
        if (pick < 4) begin
            op.op = OP_ILLEGAL;
        end else if (pick < 42) begin
            op.op = OP_ADD;
        end else if (pick < 72) begin
            op.op = OP_POST;
            if (sub < 7 && awaiting_post.size() != 0) begin
                op.id = IDX_W'(awaiting_post[$urandom_range(0, awaiting_post.size() - 1)]);
            end else if (sub < 9 && written_tab[GEN_VIEW][r]) begin
                op.id = IDX_W'(r);
            end else if (qsize[GEN_VIEW] < MAX_ENTRIES) begin
                op.id = IDX_W'($urandom_range(qsize[GEN_VIEW], MAX_ENTRIES - 1));
            end else begin
                op.op = OP_GET;
            end
        end
        return op;
    endfunction

    task automatic queue_op(input vq_op_t op);
        vq_reply_t r;
        int        k;
        logic      found;
        r = virtqueue_step(GEN_VIEW, op);
        found = 1'b0;
        if (r.status == STAT_OK && op.op == OP_ADD) begin
            awaiting_post.push_back(int'(r.head));
        end else if (r.status == STAT_OK && op.op == OP_POST) begin
            for (k = 0; k < awaiting_post.size() && !found; k++) begin
                if (awaiting_post[k] == int'(op.id)) begin
                    awaiting_post.delete(k);
                    found = 1'b1;
                end
            end
        end
        queued_ops.push_back(op);
        ops_in_flight++;
    endtask

    task automatic wait_drained();
        while (ops_in_flight != 0) begin
            @(negedge aclk);
        end
    endtask

    // Called at a falling edge with the block idle.
    task automatic program_qsize(input logic [CFG_DATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_QSIZE, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        while (!pready) begin
            @(negedge aclk);
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        ring_configure(GEN_VIEW, value);
        ring_configure(DUT_VIEW, value);
        awaiting_post.delete();
        sizes_written++;
    endtask

    task automatic run_chunk(input int count);
        int n;
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        @(posedge aclk);
        for (n = 0; n < count; n++) begin
            queue_op(random_op());
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin : driver
        vq_op_t op;
        if (!s_valid || in_fired) begin
            if (tx_wait != 0) begin
                tx_wait--;
                s_valid <= 1'b0;
            end else if (queued_ops.size() != 0) begin
                op = queued_ops.pop_front();
                s_opcode        <= op.op;
                s_buf_addr      <= op.addr;
                s_buf_len       <= op.len;
                s_device_writes <= op.dev_wr;
                s_used_id       <= op.id;
                s_used_len      <= op.used_len;
                s_valid         <= 1'b1;
                tx_wait = $urandom_range(0, tx_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // After each reply transfer the receiver draws a stall; once in the run
    // it holds off long enough for the block to back up its input.
    always @(negedge aclk) begin : receiver
        if (reply_fired) begin
            if (!long_hold_done && replies_checked > 300 && ops_in_flight > 20) begin
                rx_wait = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                rx_wait = $urandom_range(0, rx_gap_max);
            end
        end
        if (rx_wait != 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        vq_reply_t got;
        vq_reply_t want;
        if (!aresetn) begin
            in_fired    <= 1'b0;
            reply_fired <= 1'b0;
        end else begin
            in_fired    <= s_valid && s_ready;
            reply_fired <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                awaited_replies.push_back(virtqueue_step(DUT_VIEW,
                    make_op(s_opcode, s_buf_addr, s_buf_len, s_device_writes,
                            s_used_id, s_used_len)));
                op_count[s_opcode]++;
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_head, m_ret_addr, m_ret_len, m_avail_slot, m_free_count};
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual 0x%0h", $time, got);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    ops_in_flight--;
                    replies_checked++;
                    stat_count[want.status]++;
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("head", 64'(want.head), 64'(got.head));
                    check_field("ret_addr", want.ret_addr, got.ret_addr);
                    check_field("ret_len", 64'(want.ret_len), 64'(got.ret_len));
                    check_field("avail_slot", 64'(want.avail_slot), 64'(got.avail_slot));
                    check_field("free_count", 64'(want.free_count), 64'(got.free_count));
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d operations outstanding",
                     $time, STALL_LIMIT, ops_in_flight);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        int qs_value;
        ring_reset(GEN_VIEW);
        ring_reset(DUT_VIEW);
        repeat (8) begin
            @(negedge aclk);
        end
        aresetn = 1'b1;

        // Reset queue size: empty get, extreme buffers, out-of-order posts.
        @(posedge aclk);
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_ADD, '1, '1, 1'b1, '1, '1));
        queue_op(make_op(OP_ADD, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_POST, 64'h0123_4567_89ab_cdef, '0, 1'b0, 8'd1, '1));
        queue_op(make_op(OP_POST, '1, '1, 1'b1, 8'd0, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_ILLEGAL, '1, '1, 1'b1, '1, '1));
        wait_drained();

        // Two entries: bad ids, empty free list, full used ring, repeated post.
        program_qsize(32'd2);
        @(posedge aclk);
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd2, '1));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd255, '1));
        queue_op(make_op(OP_ADD, 64'hfedc_ba98_7654_3210, 32'h8000_0000, 1'b1, '0, '0));
        queue_op(make_op(OP_ADD, 64'h8000_0000_0000_0001, 32'h1, 1'b0, '0, '0));
        queue_op(make_op(OP_ADD, '1, '1, 1'b1, '0, '0));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd0, 32'hdead_beef));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd1, 32'h7fff_ffff));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd0, '1));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd0, 32'h0000_1234));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_ADD, 64'h5555_5555_5555_5555, '0, 1'b1, '0, '0));
        queue_op(make_op(OP_ADD, 64'haaaa_aaaa_aaaa_aaaa, '1, 1'b0, '0, '0));
        queue_op(make_op(OP_ADD, '0, '0, 1'b0, '0, '0));
        wait_drained();

        // A written size of zero means one entry.
        program_qsize(32'hffff_fe00);
        @(posedge aclk);
        queue_op(make_op(OP_ADD, '1, '0, 1'b1, '0, '0));
        queue_op(make_op(OP_ADD, '0, '1, 1'b0, '0, '0));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd0, 32'h0000_0040));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd0, 32'h0000_0080));
        queue_op(make_op(OP_POST, '0, '0, 1'b0, 8'd1, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        queue_op(make_op(OP_GET, '0, '0, 1'b0, '0, '0));
        wait_drained();

        // Random phases, each split in two with a full drain in between.
        for (p = 0; p < PHASES; p++) begin
            qs_value = (size_plan[p] < 0) ? $urandom_range(9, 40) : size_plan[p];
            program_qsize(($urandom & 32'hffff_fe00) | CFG_DATA_W'(qs_value));
            run_chunk(CHUNK_OPS);
            run_chunk(CHUNK_OPS);
        end

        repeat (DRAIN_CYCLES) begin
            @(negedge aclk);
        end
        if (awaited_replies.size() != 0) begin
            $display("%0t: %0d expected replies never arrived", $time, awaited_replies.size());
            mismatches++;
        end
        $display("Ran %0d adds, %0d posts, %0d gets and %0d illegal opcodes over %0d queue sizes.",
                 op_count[OP_ADD], op_count[OP_POST], op_count[OP_GET], op_count[OP_ILLEGAL],
                 sizes_written);
        $display("Replies checked %0d (ok %0d, no free %0d, nothing used %0d, bad id %0d).",
                 replies_checked, stat_count[STAT_OK], stat_count[STAT_NO_FREE],
                 stat_count[STAT_NO_USED], stat_count[STAT_BAD_ID]);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
